/* rtl/rbe_pkg.sv */
// shared types, constants and tables of the rigid body euler step block
package rbe_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int DT_BITS      = 16;
    localparam int CORDIC_ITERS = 24;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 32;
    localparam int MOT_OPS      = 13;
    localparam int QMUL_TERMS   = 16;
    localparam int CNT_W        = 6;
    localparam int ADDR_W       = 5;

    localparam logic signed [33:0] CORDIC_GAIN     = 34'sd652032874;
    localparam logic signed [33:0] HALF_TURN_SCALE = 34'sd341782638;
    localparam logic signed [33:0] PI_Q30          = 34'sd3373259426;
    localparam logic signed [31:0] Q30_ONE         = 32'sh4000_0000;

    localparam logic signed [31:0] GRAV_ACCEL_RST = -32'sd642253;
    localparam logic [30:0]        INV_MASS_RST   = 31'd65536;

    // sign of each quaternion product term, bit index {component, term}
    localparam logic [15:0] QMUL_NEG = 16'b0100_0010_1000_1110;

    typedef enum logic [2:0] {
        REG_GRAV_EN,
        REG_GRAV_ACCEL,
        REG_INV_MASS,
        REG_STATIC,
        REG_EXT_CTRL
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MOT,
        S_SQI,
        S_SQRT,
        S_LEN,
        S_CHK,
        S_PHASE,
        S_RESID,
        S_CORDIC,
        S_SPS,
        S_DIV,
        S_QMUL,
        S_QCOM,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_GRAV,
        OP_FIM,
        OP_ACC,
        OP_POS,
        OP_SQ,
        OP_LEN_DT,
        OP_PHASE,
        OP_RESID,
        OP_SPS,
        OP_QMUL
    } t_mop;

    typedef struct packed {
        t_mop       op;
        logic [1:0] axis;
    } t_mot;

    typedef struct packed {
        logic              grav_en;
        logic signed [31:0] grav_accel;
        logic [30:0]       inv_mass;
        logic              is_static;
        logic              ext_ctrl;
    } t_cfg;

    typedef struct packed {
        logic       latch;
        logic       load_pos;
        logic       mul_issue;
        logic       mul_wb;
        t_mop       op;
        logic [3:0] idx;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       cordic_step;
        logic [4:0] iter;
        logic       div_step;
        logic       quat_commit;
        logic       capture;
        logic       written;
    } t_cmd;

    typedef struct packed {
        logic op_load;
        logic no_rot;
    } t_stat;

    // motion multiply sequence: gravity, then force, velocity, position per axis, then squares
    function automatic t_mot mot_op(input logic [3:0] idx);
        t_mot m;
        m.op   = OP_SQ;
        m.axis = 2'd0;
        case (idx)
            4'd0:  begin m.op = OP_GRAV; m.axis = 2'd1; end
            4'd1:  begin m.op = OP_FIM;  m.axis = 2'd0; end
            4'd2:  begin m.op = OP_ACC;  m.axis = 2'd0; end
            4'd3:  begin m.op = OP_POS;  m.axis = 2'd0; end
            4'd4:  begin m.op = OP_FIM;  m.axis = 2'd1; end
            4'd5:  begin m.op = OP_ACC;  m.axis = 2'd1; end
            4'd6:  begin m.op = OP_POS;  m.axis = 2'd1; end
            4'd7:  begin m.op = OP_FIM;  m.axis = 2'd2; end
            4'd8:  begin m.op = OP_ACC;  m.axis = 2'd2; end
            4'd9:  begin m.op = OP_POS;  m.axis = 2'd2; end
            4'd10: begin m.op = OP_SQ;   m.axis = 2'd0; end
            4'd11: begin m.op = OP_SQ;   m.axis = 2'd1; end
            4'd12: begin m.op = OP_SQ;   m.axis = 2'd2; end
            default: begin m.op = OP_SQ; m.axis = 2'd0; end
        endcase
        return m;
    endfunction

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048576;
            5'd11: v = 34'sd524288;
            5'd12: v = 34'sd262144;
            5'd13: v = 34'sd131072;
            5'd14: v = 34'sd65536;
            5'd15: v = 34'sd32768;
            5'd16: v = 34'sd16384;
            5'd17: v = 34'sd8192;
            5'd18: v = 34'sd4096;
            5'd19: v = 34'sd2048;
            5'd20: v = 34'sd1024;
            5'd21: v = 34'sd512;
            5'd22: v = 34'sd256;
            5'd23: v = 34'sd128;
            5'd24: v = 34'sd64;
            5'd25: v = 34'sd32;
            5'd26: v = 34'sd16;
            5'd27: v = 34'sd8;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            5'd30: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/rbe_regs.sv */
// configuration register bank behind the apb-style port
module rbe_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rbe_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output rbe_pkg::t_cfg                o_cfg
);

    rbe_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grav_en    <= 1'b1;
            r_cfg.grav_accel <= rbe_pkg::GRAV_ACCEL_RST;
            r_cfg.inv_mass   <= rbe_pkg::INV_MASS_RST;
            r_cfg.is_static  <= 1'b0;
            r_cfg.ext_ctrl   <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                rbe_pkg::REG_GRAV_EN:    r_cfg.grav_en    <= pwdata[0];
                rbe_pkg::REG_GRAV_ACCEL: r_cfg.grav_accel <= pwdata;
                rbe_pkg::REG_INV_MASS:   r_cfg.inv_mass   <= pwdata[30:0];
                rbe_pkg::REG_STATIC:     r_cfg.is_static  <= pwdata[0];
                rbe_pkg::REG_EXT_CTRL:   r_cfg.ext_ctrl   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            rbe_pkg::REG_GRAV_EN:    prdata = {31'd0, r_cfg.grav_en};
            rbe_pkg::REG_GRAV_ACCEL: prdata = r_cfg.grav_accel;
            rbe_pkg::REG_INV_MASS:   prdata = {1'b0, r_cfg.inv_mass};
            rbe_pkg::REG_STATIC:     prdata = {31'd0, r_cfg.is_static};
            rbe_pkg::REG_EXT_CTRL:   prdata = {31'd0, r_cfg.ext_ctrl};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/rbe_ctrl.sv */
// sequencer that steps the datapath through one transaction
module rbe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  rbe_pkg::t_cfg  i_cfg,
    input  rbe_pkg::t_stat i_stat,
    output rbe_pkg::t_cmd  o_cmd
);

    rbe_pkg::t_state             r_state, n_state;
    logic                        r_ph, n_ph;
    logic [rbe_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [3:0]                  r_idx, n_idx;
    logic                        r_wr, n_wr;
    logic                        r_out_valid, n_out_valid;
    logic                        w_in_accept;
    logic                        w_out_free;
    rbe_pkg::t_mot               w_mot;

    assign w_in_accept = i_in_valid && (r_state == rbe_pkg::S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != rbe_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_mot       = rbe_pkg::mot_op(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbe_pkg::S_IDLE;
            r_ph        <= 1'b0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_wr        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ph        <= n_ph;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_wr        <= n_wr;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_wr    = r_wr;
        unique case (r_state)
            rbe_pkg::S_IDLE: begin
                if (w_in_accept) n_state = rbe_pkg::S_START;
            end
            rbe_pkg::S_START: begin
                n_ph  = 1'b0;
                n_idx = '0;
                n_wr  = 1'b0;
                if (i_stat.op_load || i_cfg.is_static) begin
                    n_state = rbe_pkg::S_DONE;
                end else begin
                    n_state = rbe_pkg::S_MOT;
                    n_wr    = !i_cfg.ext_ctrl;
                end
            end
            rbe_pkg::S_MOT: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    if (r_idx == 4'(rbe_pkg::MOT_OPS - 1)) n_state = rbe_pkg::S_SQI;
                    else n_idx = r_idx + 4'd1;
                end
            end
            rbe_pkg::S_SQI: begin
                n_cnt   = '0;
                n_state = rbe_pkg::S_SQRT;
            end
            rbe_pkg::S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == rbe_pkg::CNT_W'(rbe_pkg::SQRT_STEPS - 1)) n_state = rbe_pkg::S_LEN;
            end
            rbe_pkg::S_LEN: begin
                n_ph = !r_ph;
                if (r_ph) n_state = rbe_pkg::S_CHK;
            end
            rbe_pkg::S_CHK: begin
                n_state = i_stat.no_rot ? rbe_pkg::S_DONE : rbe_pkg::S_PHASE;
            end
            rbe_pkg::S_PHASE: begin
                n_ph = !r_ph;
                if (r_ph) n_state = rbe_pkg::S_RESID;
            end
            rbe_pkg::S_RESID: begin
                n_ph  = !r_ph;
                n_cnt = '0;
                if (r_ph) n_state = rbe_pkg::S_CORDIC;
            end
            rbe_pkg::S_CORDIC: begin
                n_cnt = r_cnt + 1'b1;
                n_idx = '0;
                if (r_cnt == rbe_pkg::CNT_W'(rbe_pkg::CORDIC_ITERS - 1)) n_state = rbe_pkg::S_SPS;
            end
            rbe_pkg::S_SPS: begin
                n_ph  = !r_ph;
                n_cnt = '0;
                if (r_ph) begin
                    if (r_idx == 4'd2) n_state = rbe_pkg::S_DIV;
                    else n_idx = r_idx + 4'd1;
                end
            end
            rbe_pkg::S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                n_idx = '0;
                if (r_cnt == rbe_pkg::CNT_W'(rbe_pkg::DIV_STEPS - 1)) n_state = rbe_pkg::S_QMUL;
            end
            rbe_pkg::S_QMUL: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    if (r_idx == 4'(rbe_pkg::QMUL_TERMS - 1)) n_state = rbe_pkg::S_QCOM;
                    else n_idx = r_idx + 4'd1;
                end
            end
            rbe_pkg::S_QCOM: begin
                n_state = rbe_pkg::S_DONE;
            end
            rbe_pkg::S_DONE: begin
                if (w_out_free) n_state = rbe_pkg::S_IDLE;
            end
            default: n_state = rbe_pkg::S_IDLE;
        endcase

        if ((r_state == rbe_pkg::S_DONE) && w_out_free) n_out_valid = 1'b1;
        else if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    // datapath commands
    always_comb begin
        o_cmd     = '0;
        o_cmd.op  = rbe_pkg::OP_GRAV;
        unique case (r_state)
            rbe_pkg::S_IDLE:  o_cmd.latch = w_in_accept;
            rbe_pkg::S_START: o_cmd.load_pos = i_stat.op_load;
            rbe_pkg::S_MOT: begin
                o_cmd.op        = w_mot.op;
                o_cmd.idx       = {2'b00, w_mot.axis};
                o_cmd.mul_issue = !r_ph;
                o_cmd.mul_wb    = r_ph;
            end
            rbe_pkg::S_SQI:  o_cmd.sqrt_init = 1'b1;
            rbe_pkg::S_SQRT: o_cmd.sqrt_step = 1'b1;
            rbe_pkg::S_LEN: begin
                o_cmd.op        = rbe_pkg::OP_LEN_DT;
                o_cmd.mul_issue = !r_ph;
                o_cmd.mul_wb    = r_ph;
            end
            rbe_pkg::S_CHK: ;
            rbe_pkg::S_PHASE: begin
                o_cmd.op        = rbe_pkg::OP_PHASE;
                o_cmd.mul_issue = !r_ph;
                o_cmd.mul_wb    = r_ph;
            end
            rbe_pkg::S_RESID: begin
                o_cmd.op        = rbe_pkg::OP_RESID;
                o_cmd.mul_issue = !r_ph;
                o_cmd.mul_wb    = r_ph;
            end
            rbe_pkg::S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                o_cmd.iter        = r_cnt[4:0];
            end
            rbe_pkg::S_SPS: begin
                o_cmd.op        = rbe_pkg::OP_SPS;
                o_cmd.idx       = r_idx;
                o_cmd.mul_issue = !r_ph;
                o_cmd.mul_wb    = r_ph;
            end
            rbe_pkg::S_DIV: o_cmd.div_step = 1'b1;
            rbe_pkg::S_QMUL: begin
                o_cmd.op        = rbe_pkg::OP_QMUL;
                o_cmd.idx       = r_idx;
                o_cmd.mul_issue = !r_ph;
                o_cmd.mul_wb    = r_ph;
            end
            rbe_pkg::S_QCOM: o_cmd.quat_commit = 1'b1;
            rbe_pkg::S_DONE: begin
                o_cmd.capture = w_out_free;
                o_cmd.written = r_wr;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/rbe_dpath.sv */
// body state, shared multiplier, square root, cordic and divider lanes, output register
module rbe_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbe_pkg::t_cmd      i_cmd,
    input  rbe_pkg::t_cfg      i_cfg,
    input  logic               i_operation,
    input  logic [15:0]        i_time_step,
    input  logic signed [31:0] i_force_x,
    input  logic signed [31:0] i_force_y,
    input  logic signed [31:0] i_force_z,
    input  logic signed [31:0] i_spin_x,
    input  logic signed [31:0] i_spin_y,
    input  logic signed [31:0] i_spin_z,
    input  logic signed [31:0] i_load_x,
    input  logic signed [31:0] i_load_y,
    input  logic signed [31:0] i_load_z,
    output rbe_pkg::t_stat     o_stat,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_vel_z,
    output logic signed [31:0] o_rot_w,
    output logic signed [31:0] o_rot_x,
    output logic signed [31:0] o_rot_y,
    output logic signed [31:0] o_rot_z,
    output logic               o_transform_written
);

    // latched transaction
    logic               r_op_in;
    logic [15:0]        r_dt;
    logic signed [31:0] r_force [3];
    logic signed [31:0] r_spin  [3];
    logic signed [31:0] r_load  [3];

    // body state
    logic signed [31:0] r_pos  [3];
    logic signed [31:0] r_vel  [3];
    logic signed [31:0] r_quat [4];

    // working registers
    logic signed [67:0] r_prod;
    logic signed [31:0] r_acc;
    logic [63:0]        r_sum;
    logic [63:0]        r_sq_v, r_sq_res, r_sq_bit;
    logic [31:0]        r_angle, r_phase;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic [31:0]        r_rem  [3];
    logic [31:0]        r_dvd  [3];
    logic               r_qneg [3];
    logic signed [37:0] r_qacc;
    logic signed [31:0] r_qnew [4];

    // output register
    logic signed [31:0] r_o_pos  [3];
    logic signed [31:0] r_o_vel  [3];
    logic signed [31:0] r_o_quat [4];
    logic               r_o_wr;

    logic [1:0]         w_k, w_m, w_t, w_qi;
    logic [31:0]        w_len;
    logic signed [33:0] w_a, w_b, w_c, w_s;
    logic signed [33:0] w_d [4];
    logic signed [67:0] w_shf, w_shdt, w_sh30;
    logic signed [67:0] w_mag;
    logic signed [63:0] w_vel_sum, w_pos_sum;
    logic [64:0]        w_rb;
    logic               w_sq_ge;
    logic signed [33:0] w_dx, w_dy, w_at;
    logic signed [37:0] w_term, w_qsum;

    assign w_k   = i_cmd.idx[1:0];
    assign w_m   = i_cmd.idx[3:2];
    assign w_t   = i_cmd.idx[1:0];
    assign w_qi  = w_m ^ w_t;
    assign w_len = r_sq_res[31:0];

    assign o_stat.op_load = r_op_in;
    assign o_stat.no_rot  = (r_angle == 32'd0) || (w_len == 32'd0);

    // quadrant unfold of the cordic result
    always_comb begin
        case (r_phase[31:30])
            2'd0:    begin w_c = r_cx;  w_s = r_cy;  end
            2'd1:    begin w_c = -r_cy; w_s = r_cx;  end
            2'd2:    begin w_c = -r_cx; w_s = -r_cy; end
            default: begin w_c = r_cy;  w_s = -r_cx; end
        endcase
    end

    always_comb begin
        w_d[0] = w_c;
        for (int j = 0; j < 3; j++) begin
            w_d[j+1] = r_qneg[j] ? -$signed({2'b00, r_dvd[j]}) : $signed({2'b00, r_dvd[j]});
        end
    end

    // operand select of the shared multiplier
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_cmd.op)
            rbe_pkg::OP_GRAV: begin
                w_a = {{2{i_cfg.grav_accel[31]}}, i_cfg.grav_accel};
                w_b = {18'd0, r_dt};
            end
            rbe_pkg::OP_FIM: begin
                w_a = {{2{r_force[w_k][31]}}, r_force[w_k]};
                w_b = {3'd0, i_cfg.inv_mass};
            end
            rbe_pkg::OP_ACC: begin
                w_a = {{2{r_acc[31]}}, r_acc};
                w_b = {18'd0, r_dt};
            end
            rbe_pkg::OP_POS: begin
                w_a = {{2{r_vel[w_k][31]}}, r_vel[w_k]};
                w_b = {18'd0, r_dt};
            end
            rbe_pkg::OP_SQ: begin
                w_a = {{2{r_spin[w_k][31]}}, r_spin[w_k]};
                w_b = {{2{r_spin[w_k][31]}}, r_spin[w_k]};
            end
            rbe_pkg::OP_LEN_DT: begin
                w_a = {2'd0, w_len};
                w_b = {18'd0, r_dt};
            end
            rbe_pkg::OP_PHASE: begin
                w_a = {2'd0, r_angle};
                w_b = rbe_pkg::HALF_TURN_SCALE;
            end
            rbe_pkg::OP_RESID: begin
                w_a = {4'd0, r_phase[29:0]};
                w_b = rbe_pkg::PI_Q30;
            end
            rbe_pkg::OP_SPS: begin
                w_a = {{2{r_spin[w_k][31]}}, r_spin[w_k]};
                w_b = w_s;
            end
            rbe_pkg::OP_QMUL: begin
                w_a = w_d[w_t];
                w_b = {{2{r_quat[w_qi][31]}}, r_quat[w_qi]};
            end
            default: ;
        endcase
    end

    assign w_shf     = r_prod >>> rbe_pkg::FRAC_BITS;
    assign w_shdt    = r_prod >>> rbe_pkg::DT_BITS;
    assign w_sh30    = r_prod >>> 30;
    assign w_mag     = r_prod[67] ? -r_prod : r_prod;
    assign w_vel_sum = {{32{r_vel[w_k][31]}}, r_vel[w_k]} + w_shdt[63:0];
    assign w_pos_sum = {{32{r_pos[w_k][31]}}, r_pos[w_k]} + w_shdt[63:0];
    assign w_term    = rbe_pkg::QMUL_NEG[i_cmd.idx] ? -w_sh30[37:0] : w_sh30[37:0];
    assign w_qsum    = ((w_t == 2'd0) ? 38'sd0 : r_qacc) + w_term;

    // bit-pair square root step
    assign w_rb    = {1'b0, r_sq_res} + {1'b0, r_sq_bit};
    assign w_sq_ge = ({1'b0, r_sq_v} >= w_rb);

    // one cordic rotation
    assign w_dx = r_cy >>> i_cmd.iter;
    assign w_dy = r_cx >>> i_cmd.iter;
    assign w_at = rbe_pkg::atan_q30(i_cmd.iter);

    // body state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
                r_vel[k] <= '0;
            end
            r_quat[0] <= rbe_pkg::Q30_ONE;
            r_quat[1] <= '0;
            r_quat[2] <= '0;
            r_quat[3] <= '0;
        end else begin
            if (i_cmd.load_pos) begin
                for (int k = 0; k < 3; k++) r_pos[k] <= r_load[k];
            end
            if (i_cmd.mul_wb) begin
                case (i_cmd.op)
                    rbe_pkg::OP_GRAV: begin
                        if (i_cfg.grav_en) r_vel[1] <= rbe_pkg::sat32(w_vel_sum);
                    end
                    rbe_pkg::OP_ACC: r_vel[w_k] <= rbe_pkg::sat32(w_vel_sum);
                    rbe_pkg::OP_POS: r_pos[w_k] <= rbe_pkg::sat32(w_pos_sum);
                    default: ;
                endcase
            end
            if (i_cmd.quat_commit) begin
                for (int j = 0; j < 4; j++) r_quat[j] <= r_qnew[j];
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op_in  <= i_operation;
            r_dt     <= i_time_step;
            r_force[0] <= i_force_x;
            r_force[1] <= i_force_y;
            r_force[2] <= i_force_z;
            r_spin[0]  <= i_spin_x;
            r_spin[1]  <= i_spin_y;
            r_spin[2]  <= i_spin_z;
            r_load[0]  <= i_load_x;
            r_load[1]  <= i_load_y;
            r_load[2]  <= i_load_z;
        end
        if (i_cmd.mul_issue) r_prod <= w_a * w_b;
        if (i_cmd.mul_wb) begin
            case (i_cmd.op)
                rbe_pkg::OP_FIM: r_acc <= rbe_pkg::sat32(w_shf[63:0]);
                rbe_pkg::OP_SQ: begin
                    if (w_k == 2'd0) r_sum <= r_prod[63:0];
                    else r_sum <= r_sum + r_prod[63:0];
                end
                rbe_pkg::OP_LEN_DT: r_angle <= r_prod[47:16];
                rbe_pkg::OP_PHASE:  r_phase <= r_prod[rbe_pkg::FRAC_BITS+31:rbe_pkg::FRAC_BITS];
                rbe_pkg::OP_RESID: begin
                    r_cz <= r_prod[64:31];
                    r_cx <= rbe_pkg::CORDIC_GAIN;
                    r_cy <= '0;
                end
                rbe_pkg::OP_SPS: begin
                    r_qneg[w_k] <= r_prod[67];
                    r_rem[w_k]  <= w_mag[63:32];
                    r_dvd[w_k]  <= w_mag[31:0];
                end
                rbe_pkg::OP_QMUL: begin
                    r_qacc <= w_qsum;
                    if (w_t == 2'd3) r_qnew[w_m] <= rbe_pkg::sat32({{26{w_qsum[37]}}, w_qsum});
                end
                default: ;
            endcase
        end
        if (i_cmd.sqrt_init) begin
            r_sq_v   <= r_sum;
            r_sq_res <= '0;
            r_sq_bit <= 64'd1 << 62;
        end
        if (i_cmd.sqrt_step) begin
            if (w_sq_ge) begin
                r_sq_v   <= r_sq_v - w_rb[63:0];
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
        if (i_cmd.cordic_step) begin
            if (!r_cz[33]) begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - w_at;
            end else begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + w_at;
            end
        end
        // restoring division, quotient bits shift into the dividend register
        if (i_cmd.div_step) begin
            for (int k = 0; k < 3; k++) begin
                if ({r_rem[k], r_dvd[k][31]} >= {1'b0, w_len}) begin
                    r_rem[k] <= 32'({r_rem[k], r_dvd[k][31]} - {1'b0, w_len});
                    r_dvd[k] <= {r_dvd[k][30:0], 1'b1};
                end else begin
                    r_rem[k] <= {r_rem[k][30:0], r_dvd[k][31]};
                    r_dvd[k] <= {r_dvd[k][30:0], 1'b0};
                end
            end
        end
        if (i_cmd.capture) begin
            for (int k = 0; k < 3; k++) begin
                r_o_pos[k] <= r_pos[k];
                r_o_vel[k] <= r_vel[k];
            end
            for (int j = 0; j < 4; j++) r_o_quat[j] <= r_quat[j];
            r_o_wr <= i_cmd.written;
        end
    end

    assign o_pos_x = r_o_pos[0];
    assign o_pos_y = r_o_pos[1];
    assign o_pos_z = r_o_pos[2];
    assign o_vel_x = r_o_vel[0];
    assign o_vel_y = r_o_vel[1];
    assign o_vel_z = r_o_vel[2];
    assign o_rot_w = r_o_quat[0];
    assign o_rot_x = r_o_quat[1];
    assign o_rot_y = r_o_quat[2];
    assign o_rot_z = r_o_quat[3];
    assign o_transform_written = r_o_wr;

endmodule

/* rtl/rigid_body_euler_step.sv */
// top level of the rigid body euler step block
//
//  channel   handshake                  payload
//  input     i_in_valid / o_in_stall    i_operation, i_time_step, i_force_*, i_spin_*, i_load_*
//  output    o_out_valid / i_out_stall  o_pos_*, o_vel_*, o_rot_*, o_transform_written
//  config    psel penable pwrite pready paddr, pwdata, prdata
//
//  one transaction at a time; a load or a static step goes straight to the result, a step
//  with zero angle ends once the angle is known, and a rotating step goes on through
//  the CORDIC_ITERS cordic rotations; the work runs on the shared multiplier (35 products),
//  the 32-step square root and the 32-step divider lanes.
//  a finished result sits in the output register; the next transaction is taken
//  while it waits, and the block holds in its last state until the register is free.
//  reset is synchronous and restores the identity orientation and the register defaults.
module rigid_body_euler_step (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_operation,
    input  logic [15:0]                i_time_step,
    input  logic signed [31:0]         i_force_x,
    input  logic signed [31:0]         i_force_y,
    input  logic signed [31:0]         i_force_z,
    input  logic signed [31:0]         i_spin_x,
    input  logic signed [31:0]         i_spin_y,
    input  logic signed [31:0]         i_spin_z,
    input  logic signed [31:0]         i_load_x,
    input  logic signed [31:0]         i_load_y,
    input  logic signed [31:0]         i_load_z,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [31:0]         o_pos_x,
    output logic signed [31:0]         o_pos_y,
    output logic signed [31:0]         o_pos_z,
    output logic signed [31:0]         o_vel_x,
    output logic signed [31:0]         o_vel_y,
    output logic signed [31:0]         o_vel_z,
    output logic signed [31:0]         o_rot_w,
    output logic signed [31:0]         o_rot_x,
    output logic signed [31:0]         o_rot_y,
    output logic signed [31:0]         o_rot_z,
    output logic                       o_transform_written,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rbe_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    rbe_pkg::t_cfg  w_cfg;
    rbe_pkg::t_cmd  w_cmd;
    rbe_pkg::t_stat w_stat;

    rbe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg       (w_cfg),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    rbe_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_cfg               (w_cfg),
        .i_operation         (i_operation),
        .i_time_step         (i_time_step),
        .i_force_x           (i_force_x),
        .i_force_y           (i_force_y),
        .i_force_z           (i_force_z),
        .i_spin_x            (i_spin_x),
        .i_spin_y            (i_spin_y),
        .i_spin_z            (i_spin_z),
        .i_load_x            (i_load_x),
        .i_load_y            (i_load_y),
        .i_load_z            (i_load_z),
        .o_stat              (w_stat),
        .o_pos_x             (o_pos_x),
        .o_pos_y             (o_pos_y),
        .o_pos_z             (o_pos_z),
        .o_vel_x             (o_vel_x),
        .o_vel_y             (o_vel_y),
        .o_vel_z             (o_vel_z),
        .o_rot_w             (o_rot_w),
        .o_rot_x             (o_rot_x),
        .o_rot_y             (o_rot_y),
        .o_rot_z             (o_rot_z),
        .o_transform_written (o_transform_written)
    );

endmodule

/* rtl/rbe_checker.sv */
// port-level checks of the rigid body euler step block, bound to the top level
module rbe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_pos_x,
    input logic [31:0] o_rot_w
);

    // a transaction taken makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transaction was taken");

    // reset leaves the block empty and ready
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not empty after reset");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_pos_x) && $stable(o_rot_w)))
        else $error("stalled result changed");

endmodule

bind rigid_body_euler_step rbe_checker u_rbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pos_x     (o_pos_x),
    .o_rot_w     (o_rot_w)
);
